@@ src/adq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adq_pkg
// Shared types and constants for the array deque with search: op codes,
// result status codes, controller states and the result beat struct.
// ----------------------------------------------------------------------------
package adq_pkg;

  // default number of slots in the store
  localparam int DEPTH_DEF = 8;

  // most results reported by one search or modify
  localparam int REPORT_LIMIT = 8;

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 3;

  // op codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_MODIFY     = 3'd5;

  // data returned by a pop on an empty deque
  localparam logic signed [DATA_W-1:0] POP_EMPTY_DATA = -32'sd1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_DONE
  } state_t;

  // one result beat handed from the controller to the output register
  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } emit_t;

endpackage
`default_nettype wire

@@ src/adq_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adq_store
// Slot memory of the deque: one write port and one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module adq_store
  import adq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic signed [DATA_W-1:0]       wdata,
  input  wire logic                           re,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic signed [DATA_W-1:0]            rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/adq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adq_ctrl
// Sequencer of the deque: holds the front and back indices, runs pushes
// and pops, and walks the slots from front to back through the single
// comparator for search and modify.
// ----------------------------------------------------------------------------
module adq_ctrl
  import adq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [OP_W-1:0]                op,
  input  wire logic signed [DATA_W-1:0]       value,
  input  wire logic signed [DATA_W-1:0]       new_value,
  input  wire logic                           out_free,
  output emit_t                               emit,
  output logic                                we,
  output logic [$clog2(DEPTH)-1:0]            waddr,
  output logic signed [DATA_W-1:0]            wdata,
  output logic                                re,
  output logic [$clog2(DEPTH)-1:0]            raddr,
  input  wire logic signed [DATA_W-1:0]       rdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(REPORT_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(REPORT_LIMIT);

  state_t state, state_next;

  logic                     empty;
  logic [IDX_W-1:0]         front;
  logic [IDX_W-1:0]         back;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         slot;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] repl;
  logic                     rewrite;
  logic [CNT_W-1:0]         cnt;
  logic                     pend_v;
  logic signed [DATA_W-1:0] pend_data;
  logic [IDX_W-1:0]         pend_pos;

  logic             accept;
  logic             is_push;
  logic             is_pop;
  logic             is_scan;
  logic             at_back;
  logic             push_full;
  logic [IDX_W-1:0] push_slot;
  logic [IDX_W-1:0] pop_slot;
  logic             hit;
  logic             take;
  logic             scan_go;
  logic             scan_end;

  // input handshake and op decode
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign is_push  = (op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT);
  assign is_pop   = (op == OP_POP_BACK) || (op == OP_POP_FRONT);
  assign is_scan  = (op == OP_SEARCH) || (op == OP_MODIFY);
  assign at_back  = (op == OP_PUSH_BACK) || (op == OP_POP_BACK);

  // push and pop slot selection
  assign push_full = !empty && (at_back ? (back == LAST_SLOT) : (front == '0));
  assign push_slot = empty ? '0 : (at_back ? back + 1'b1 : front - 1'b1);
  assign pop_slot  = at_back ? back : front;

  // shared comparator
  assign hit      = (rdata == key);
  assign take     = hit && (cnt < CNT_LIMIT);
  assign scan_go  = !(take && pend_v && !out_free);
  assign scan_end = (idx == back);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !empty && is_pop) begin
          state_next = ST_POP;
        end else if (accept && !empty && is_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_POP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_go && scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: result beats and memory accesses
  always_comb begin
    emit  = '0;
    we    = 1'b0;
    waddr = idx;
    wdata = repl;
    re    = 1'b0;
    raddr = idx;
    case (state)
      ST_IDLE: begin
        if (accept && is_push) begin
          emit.valid  = 1'b1;
          emit.last   = 1'b1;
          emit.status = push_full ? STAT_FULL : STAT_OK;
          if (!push_full) begin
            we    = 1'b1;
            waddr = push_slot;
            wdata = value;
          end
        end else if (accept && is_pop) begin
          if (empty) begin
            emit.valid  = 1'b1;
            emit.last   = 1'b1;
            emit.status = STAT_EMPTY;
            emit.data   = POP_EMPTY_DATA;
          end else begin
            re    = 1'b1;
            raddr = pop_slot;
          end
        end else if (accept && is_scan) begin
          if (empty) begin
            emit.valid  = 1'b1;
            emit.last   = 1'b1;
            emit.status = STAT_EMPTY;
          end else begin
            re    = 1'b1;
            raddr = front;
          end
        end
      end
      ST_POP: begin
        emit.valid    = out_free;
        emit.status   = STAT_OK;
        emit.data     = rdata;
        emit.position = POS_W'(slot);
        emit.last     = 1'b1;
      end
      ST_SCAN: begin
        // a new match pushes the held one out, not as the final beat
        if (take && pend_v && out_free) begin
          emit.valid    = 1'b1;
          emit.status   = STAT_OK;
          emit.data     = pend_data;
          emit.position = POS_W'(pend_pos);
        end
        if (scan_go) begin
          if (hit && rewrite) begin
            we    = 1'b1;
            waddr = idx;
            wdata = repl;
          end
          if (!scan_end) begin
            re    = 1'b1;
            raddr = idx + 1'b1;
          end
        end
      end
      ST_DONE: begin
        emit.valid = out_free;
        emit.last  = 1'b1;
        if (pend_v) begin
          emit.status   = STAT_OK;
          emit.data     = pend_data;
          emit.position = POS_W'(pend_pos);
        end else begin
          emit.status = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // state and deque indices
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      empty  <= 1'b1;
      front  <= '0;
      back   <= '0;
      pend_v <= 1'b0;
      cnt    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        if (is_push && !push_full) begin
          if (empty) begin
            empty <= 1'b0;
            front <= '0;
            back  <= '0;
          end else if (at_back) begin
            back <= back + 1'b1;
          end else begin
            front <= front - 1'b1;
          end
        end else if (is_pop && !empty) begin
          if (back == front) begin
            empty <= 1'b1;
            front <= '0;
            back  <= '0;
          end else if (at_back) begin
            back <= back - 1'b1;
          end else begin
            front <= front + 1'b1;
          end
        end else if (is_scan && !empty) begin
          pend_v <= 1'b0;
          cnt    <= '0;
        end
      end else if (state == ST_SCAN && scan_go && take) begin
        pend_v <= 1'b1;
        cnt    <= cnt + 1'b1;
      end
    end
  end

  // operation payload and scan position
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      slot    <= pop_slot;
      idx     <= front;
      key     <= value;
      repl    <= new_value;
      rewrite <= (op == OP_MODIFY);
    end else if (state == ST_SCAN && scan_go) begin
      if (take) begin
        pend_data <= rdata;
        pend_pos  <= idx;
      end
      if (!scan_end) begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/array_deque_with_search_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_deque_with_search_core
// Array deque of DEPTH signed words with search and modify.
// ----------------------------------------------------------------------------
// A push ends once its beat is registered; the next item can follow right
// after it. A pop reads its word through the registered read port of the
// slot store. In a search or modify the read port streams the slots from
// front to back into one comparator, one slot per cycle save while a new
// match waits on a stalled output register, and a modify writes each match
// back through the write port in the same pass. Input is stalled while an
// item is in progress or a result beat sits stalled in the output register;
// a new item is taken only in a cycle where that register is empty or its
// beat is taken. Each push, pop, search or modify gives one or more beats,
// the final one marked by last; reserved ops give none. Search and modify
// report at most REPORT_LIMIT matches, lowest slots first.
// ----------------------------------------------------------------------------
module array_deque_with_search_core
  import adq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          op,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic signed [DATA_W-1:0] new_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      data,
  output logic [POS_W-1:0]              position,
  output logic                          last
);

  localparam int IDX_W = $clog2(DEPTH);

  emit_t                    emit;
  logic                     out_free;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     re;
  logic [IDX_W-1:0]         raddr;
  logic signed [DATA_W-1:0] rdata;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // sequencer
  adq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value     (value),
    .new_value (new_value),
    .out_free  (out_free),
    .emit      (emit),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // slot store
  adq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      status   <= emit.status;
      data     <= emit.data;
      position <= emit.position;
      last     <= emit.last;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_array_deque_with_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_deque_with_search_core
// Self-checking bench for the array deque with search and modify. Directed
// items hit the empty, full, no-match and many-match cases. Random items then
// fill and drain the deque under four idle and stall mixes. A predictor keeps
// its own copy of the slots and indices, and every result beat is compared
// field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_array_deque_with_search_core;
  import adq_pkg::*;

  localparam int SLOTS = DEPTH_DEF;

  // op codes that the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 24;
  localparam int RUN_LIMIT_NS = 2_000_000;

  // one predicted result beat
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } beat_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] new_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic [POS_W-1:0]         position;
  logic                     last;

  // predictor copy of the deque
  logic signed [DATA_W-1:0] slot_word [SLOTS];
  int                       back_slot;
  int                       front_slot;
  bit                       deque_empty;

  beat_t pending_beats [$];
  int    mismatch_count;
  int    idle_pct;
  int    stall_pct;

  array_deque_with_search_core #(
    .DEPTH(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .value    (value),
    .new_value(new_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .data     (data),
    .position (position),
    .last     (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_array_deque_with_search_core failed");
    $finish;
  end

  function automatic void queue_beat(status_t st, logic signed [DATA_W-1:0] d,
                                     logic [POS_W-1:0] pos, logic fin);
    beat_t b;
    b.status   = st;
    b.data     = d;
    b.position = pos;
    b.last     = fin;
    pending_beats.push_back(b);
  endfunction

  // predict the beats of one accepted item and update the deque copy
  function automatic void apply_deque_op(logic [OP_W-1:0] o,
                                         logic signed [DATA_W-1:0] v,
                                         logic signed [DATA_W-1:0] nv);
    int hit_slot [$];
    int slot;
    case (o)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (deque_empty) begin
          // first element always lands in slot 0
          front_slot   = 0;
          back_slot    = 0;
          slot_word[0] = v;
          deque_empty  = 1'b0;
          queue_beat(STAT_OK, '0, '0, 1'b1);
        end else if (o == OP_PUSH_BACK && back_slot == SLOTS - 1) begin
          queue_beat(STAT_FULL, '0, '0, 1'b1);
        end else if (o == OP_PUSH_FRONT && front_slot == 0) begin
          queue_beat(STAT_FULL, '0, '0, 1'b1);
        end else if (o == OP_PUSH_BACK) begin
          back_slot++;
          slot_word[back_slot] = v;
          queue_beat(STAT_OK, '0, '0, 1'b1);
        end else begin
          front_slot--;
          slot_word[front_slot] = v;
          queue_beat(STAT_OK, '0, '0, 1'b1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (deque_empty) begin
          queue_beat(STAT_EMPTY, POP_EMPTY_DATA, '0, 1'b1);
        end else begin
          slot = (o == OP_POP_BACK) ? back_slot : front_slot;
          queue_beat(STAT_OK, slot_word[slot], POS_W'(slot), 1'b1);
          // popping the last element resets both indices
          if (back_slot == front_slot) begin
            deque_empty = 1'b1;
            back_slot   = 0;
            front_slot  = 0;
          end else if (o == OP_POP_BACK) begin
            back_slot--;
          end else begin
            front_slot++;
          end
        end
      end
      OP_SEARCH, OP_MODIFY: begin
        if (deque_empty) begin
          queue_beat(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          // walk front to back; modify rewrites every match, reports are capped
          for (int i = front_slot; i <= back_slot; i++) begin
            if (slot_word[i] == v) begin
              if (hit_slot.size() < REPORT_LIMIT) hit_slot.push_back(i);
              if (o == OP_MODIFY) slot_word[i] = nv;
            end
          end
          if (hit_slot.size() == 0) begin
            queue_beat(STAT_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            foreach (hit_slot[k])
              queue_beat(STAT_OK, v, POS_W'(hit_slot[k]), k == hit_slot.size() - 1);
          end
        end
      end
      default: begin
        // reserved op: no beat, no change
      end
    endcase
  endfunction

  // word source biased toward a small pool so that searches hit
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return -32'sd1;
      3, 4: return DATA_W'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  // present one beat on the input side and wait until it is taken
  task automatic send_item(input logic [OP_W-1:0] o, input logic signed [DATA_W-1:0] v,
                           input logic signed [DATA_W-1:0] nv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    value     <= v;
    new_value <= nv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_deque_op(o, v, nv);
  endtask

  // hold off the sender until every predicted beat has come out
  task automatic wait_all_beats();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  // pops, search and modify on an empty deque, plus reserved ops
  task automatic test_empty_ops();
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_POP_FRONT, WORD_MAX, '0);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_MODIFY, WORD_MIN, WORD_MAX);
    send_item(OP_RSVD_LO, WORD_MAX, WORD_MIN);
    send_item(OP_RSVD_HI, -32'sd1, -32'sd1);
  endtask

  // extreme words, front full at slot 0, front push after a front pop
  task automatic test_push_extremes();
    send_item(OP_PUSH_BACK, WORD_MIN, '0);
    send_item(OP_PUSH_BACK, WORD_MAX, '0);
    send_item(OP_PUSH_BACK, '0, '0);
    send_item(OP_PUSH_BACK, -32'sd1, '0);
    send_item(OP_PUSH_FRONT, 32'sd7, '0);
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_PUSH_FRONT, WORD_MAX, '0);
    send_item(OP_SEARCH, WORD_MAX, '0);
    send_item(OP_MODIFY, WORD_MAX, WORD_MIN);
    send_item(OP_SEARCH, WORD_MAX, '0);
  endtask

  // back full, then every slot matching one search
  task automatic test_full_match();
    repeat (4) send_item(OP_PUSH_BACK, -32'sd1, '0);
    send_item(OP_PUSH_BACK, 32'sd5, '0);
    send_item(OP_MODIFY, WORD_MIN, -32'sd1);
    send_item(OP_MODIFY, '0, -32'sd1);
    send_item(OP_SEARCH, -32'sd1, '0);
    send_item(OP_POP_BACK, '0, '0);
  endtask

  // random ops, alternating fill-heavy and drain-heavy stretches
  task automatic test_random_mix(input int n_items);
    int              sent;
    int              roll;
    bit              filling;
    logic [OP_W-1:0] o;
    sent = 0;
    while (sent < n_items) begin
      filling = (sent % 40) < 20;
      roll    = $urandom_range(99);
      if (roll < 3)
        o = $urandom_range(1) ? OP_RSVD_HI : OP_RSVD_LO;
      else if (roll < (filling ? 58 : 18))
        o = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (roll < 73)
        o = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      else
        o = $urandom_range(1) ? OP_SEARCH : OP_MODIFY;
      send_item(o, pick_word(), pick_word());
      if (o != OP_RSVD_LO && o != OP_RSVD_HI) sent++;
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin : result_check
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: beat with nothing pending: status=%0d data=%0d pos=%0d last=%0b",
                   $time, status, data, position, last);
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (status !== want.status || data !== want.data ||
            position !== want.position || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $write("%0t: beat mismatch: expected status=%0d data=%0d pos=%0d last=%0b,",
                   $time, want.status, $signed(want.data), want.position, want.last);
            $display(" got status=%0d data=%0d pos=%0d last=%0b",
                     status, data, position, last);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // test sequence
  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    op             <= OP_PUSH_BACK;
    value          <= '0;
    new_value      <= '0;
    out_stall      <= 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    deque_empty    = 1'b1;
    back_slot      = 0;
    front_slot     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_ops();
    test_push_extremes();
    test_full_match();
    wait_all_beats();

    // no idling
    test_random_mix(100);
    wait_all_beats();

    // sender gaps
    idle_pct = 69;
    test_random_mix(100);
    wait_all_beats();

    // receiver stalls
    idle_pct  = 0;
    stall_pct = 69;
    test_random_mix(100);
    wait_all_beats();

    // both sides
    idle_pct  = 38;
    stall_pct = 38;
    test_random_mix(100);
    wait_all_beats();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("tb_array_deque_with_search_core passed");
    end else begin
      $display("tb_array_deque_with_search_core failed");
    end
    $finish;
  end

endmodule
